// File: rtl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and constants for the segment intersection block
// Status codes and default coordinate width.
// ----------------------------------------------------------------------------
package ssi_pkg;

  // default coordinate width (Q12.4)
  localparam int unsigned COORD_BITS_DEF = 16;

  // result status codes
  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_MISS     = 2'd2
  } status_e;

endpackage

// File: rtl/segment_segment_intersect.sv
// ----------------------------------------------------------------------------
// segment_segment_intersect: pipelined 2D segment/segment intersection
// Exact fixed-point crossing test with the hit point from a pipelined divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one item holds both segments (P1, P2, Q1, Q2),
//   eight signed coordinates packed in tdata, p1_x in the lowest bits.
//   Output stream m_axis_*: one item per input with status, hit_x, hit_y.
//   status 0 = segments meet, 1 = parallel or collinear, 2 = lines cross
//   outside the segments; hit_x/hit_y are zero unless status is 0.
// Pipeline:
//   Six arithmetic stages, one restoring-divider stage per quotient bit and
//   one output register; one item per cycle unless the receiver stalls.
//   The divider is fully unrolled.
// Flow control:
//   The whole pipeline advances together whenever the output register is
//   empty or being taken. When the receiver stalls with a result waiting,
//   every stage holds and s_axis_tready_o drops; nothing is lost or repeated.
// Reset:
//   rst_ni clears all stage valid bits; the block is ready right after.
// ----------------------------------------------------------------------------
module segment_segment_intersect
  import ssi_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // fields from bit 0 up: p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y
  input  logic [((8*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // fields from bit 0 up: status, hit_x, hit_y
  output logic [((2+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned VW    = C + 1;         // coordinate difference
  localparam int unsigned PW    = 2 * C + 2;     // product of differences
  localparam int unsigned DW    = 2 * C + 3;     // cross product
  localparam int unsigned LO    = C + 2;         // low split of numerator
  localparam int unsigned HI    = DW - LO;       // high split of numerator
  localparam int unsigned NW    = 3 * C + 3;     // dividend
  localparam int unsigned NST   = C + 7;         // pipeline stages
  localparam int unsigned OUT_W = ((2 + 2 * C + 7) / 8) * 8;

  logic [NST-1:0] vld_q, vld_d;
  logic           adv;

  // global advance: output empty or being taken
  assign adv             = !vld_q[NST-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign vld_d           = {vld_q[NST-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // stage 1: unpack and take differences
  logic signed [C-1:0]  in_p1x, in_p1y, in_p2x, in_p2y;
  logic signed [C-1:0]  in_q1x, in_q1y, in_q2x, in_q2y;
  logic signed [VW-1:0] vx_d, vy_d, ux_d, uy_d, wx_d, wy_d;
  logic signed [VW-1:0] vx1_q, vy1_q, ux1_q, uy1_q, wx1_q, wy1_q;
  logic signed [C-1:0]  p1x1_q, p1y1_q;

  assign in_p1x = s_axis_tdata_i[0*C +: C];
  assign in_p1y = s_axis_tdata_i[1*C +: C];
  assign in_p2x = s_axis_tdata_i[2*C +: C];
  assign in_p2y = s_axis_tdata_i[3*C +: C];
  assign in_q1x = s_axis_tdata_i[4*C +: C];
  assign in_q1y = s_axis_tdata_i[5*C +: C];
  assign in_q2x = s_axis_tdata_i[6*C +: C];
  assign in_q2y = s_axis_tdata_i[7*C +: C];

  always_comb begin
    vx_d = VW'(in_p2x) - VW'(in_p1x);
    vy_d = VW'(in_p2y) - VW'(in_p1y);
    ux_d = VW'(in_q2x) - VW'(in_q1x);
    uy_d = VW'(in_q2y) - VW'(in_q1y);
    wx_d = VW'(in_p1x) - VW'(in_q1x);
    wy_d = VW'(in_p1y) - VW'(in_q1y);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vx1_q  <= vx_d;
      vy1_q  <= vy_d;
      ux1_q  <= ux_d;
      uy1_q  <= uy_d;
      wx1_q  <= wx_d;
      wy1_q  <= wy_d;
      p1x1_q <= in_p1x;
      p1y1_q <= in_p1y;
    end
  end

  // stage 2: the six products of the cross terms
  logic signed [PW-1:0] m_uxvy_q, m_uyvx_q, m_wxuy_q, m_wyux_q, m_wxvy_q, m_wyvx_q;
  logic signed [VW-1:0] vx2_q, vy2_q;
  logic signed [C-1:0]  p1x2_q, p1y2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_uxvy_q <= PW'(ux1_q) * PW'(vy1_q);
      m_uyvx_q <= PW'(uy1_q) * PW'(vx1_q);
      m_wxuy_q <= PW'(wx1_q) * PW'(uy1_q);
      m_wyux_q <= PW'(wy1_q) * PW'(ux1_q);
      m_wxvy_q <= PW'(wx1_q) * PW'(vy1_q);
      m_wyvx_q <= PW'(wy1_q) * PW'(vx1_q);
      vx2_q    <= vx1_q;
      vy2_q    <= vy1_q;
      p1x2_q   <= p1x1_q;
      p1y2_q   <= p1y1_q;
    end
  end

  // stage 3: denominator and both numerators
  logic signed [DW-1:0] d3_q, tn3_q, sn3_q;
  logic signed [VW-1:0] vx3_q, vy3_q;
  logic signed [C-1:0]  p1x3_q, p1y3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d3_q   <= DW'(m_uxvy_q) - DW'(m_uyvx_q);
      tn3_q  <= DW'(m_wxuy_q) - DW'(m_wyux_q);
      sn3_q  <= DW'(m_wxvy_q) - DW'(m_wyvx_q);
      vx3_q  <= vx2_q;
      vy3_q  <= vy2_q;
      p1x3_q <= p1x2_q;
      p1y3_q <= p1y2_q;
    end
  end

  // stage 4: make the denominator positive, split direction into sign/magnitude
  logic signed [DW-1:0] d4_q, tn4_q, sn4_q;
  logic                 dz4_q, sx4_q, sy4_q;
  logic [C-1:0]         ax4_q, ay4_q;
  logic signed [C-1:0]  p1x4_q, p1y4_q;
  logic signed [VW-1:0] vx_abs, vy_abs;

  assign vx_abs = vx3_q[VW-1] ? -vx3_q : vx3_q;
  assign vy_abs = vy3_q[VW-1] ? -vy3_q : vy3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d4_q   <= d3_q[DW-1] ? -d3_q  : d3_q;
      tn4_q  <= d3_q[DW-1] ? -tn3_q : tn3_q;
      sn4_q  <= d3_q[DW-1] ? -sn3_q : sn3_q;
      dz4_q  <= (d3_q == '0);
      sx4_q  <= vx3_q[VW-1];
      sy4_q  <= vy3_q[VW-1];
      ax4_q  <= vx_abs[C-1:0];
      ay4_q  <= vy_abs[C-1:0];
      p1x4_q <= p1x3_q;
      p1y4_q <= p1y3_q;
    end
  end

  // stage 5: range test and split partial products of |v| * t_num
  status_e              st_d, st5_q;
  logic [C+LO-1:0]      plx5_q, ply5_q;
  logic [C+HI-1:0]      phx5_q, phy5_q;
  logic [DW-1:0]        d5_q;
  logic                 sx5_q, sy5_q;
  logic signed [C-1:0]  p1x5_q, p1y5_q;
  logic [LO-1:0]        tn_lo;
  logic [HI-1:0]        tn_hi;

  assign tn_lo = tn4_q[LO-1:0];
  assign tn_hi = tn4_q[DW-1:LO];

  always_comb begin
    priority if (dz4_q) begin
      st_d = ST_PARALLEL;
    end else if (tn4_q < 0 || tn4_q > d4_q || sn4_q < 0 || sn4_q > d4_q) begin
      st_d = ST_MISS;
    end else begin
      st_d = ST_HIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st5_q  <= st_d;
      plx5_q <= (C+LO)'(ax4_q) * (C+LO)'(tn_lo);
      ply5_q <= (C+LO)'(ay4_q) * (C+LO)'(tn_lo);
      phx5_q <= (C+HI)'(ax4_q) * (C+HI)'(tn_hi);
      phy5_q <= (C+HI)'(ay4_q) * (C+HI)'(tn_hi);
      d5_q   <= d4_q;
      sx5_q  <= sx4_q;
      sy5_q  <= sy4_q;
      p1x5_q <= p1x4_q;
      p1y5_q <= p1y4_q;
    end
  end

  // stage 6: join partial products into the dividends (divider entry, index 0)
  logic [NW-1:0]       rx_q [0:C];
  logic [NW-1:0]       ry_q [0:C];
  logic [C-1:0]        qx_q [0:C];
  logic [C-1:0]        qy_q [0:C];
  logic [DW-1:0]       dd_q [0:C];
  status_e             st_q [0:C];
  logic                sx_q [0:C];
  logic                sy_q [0:C];
  logic signed [C-1:0] px_q [0:C];
  logic signed [C-1:0] py_q [0:C];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q[0] <= NW'(plx5_q) + (NW'(phx5_q) << LO);
      ry_q[0] <= NW'(ply5_q) + (NW'(phy5_q) << LO);
      qx_q[0] <= '0;
      qy_q[0] <= '0;
      dd_q[0] <= d5_q;
      st_q[0] <= st5_q;
      sx_q[0] <= sx5_q;
      sy_q[0] <= sy5_q;
      px_q[0] <= p1x5_q;
      py_q[0] <= p1y5_q;
    end
  end

  // restoring divider: one quotient bit per stage, most significant first
  for (genvar k = 0; k < C; k++) begin : g_div
    localparam int unsigned B = C - 1 - k;
    logic [NW-1:0] dsh;
    logic [NW:0]   trx, try_;

    assign dsh  = NW'(dd_q[k]) << B;
    assign trx  = {1'b0, rx_q[k]} - {1'b0, dsh};
    assign try_ = {1'b0, ry_q[k]} - {1'b0, dsh};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rx_q[k+1]    <= trx[NW]  ? rx_q[k] : trx[NW-1:0];
        ry_q[k+1]    <= try_[NW] ? ry_q[k] : try_[NW-1:0];
        qx_q[k+1]    <= qx_q[k] | (C'(!trx[NW])  << B);
        qy_q[k+1]    <= qy_q[k] | (C'(!try_[NW]) << B);
        dd_q[k+1]    <= dd_q[k];
        st_q[k+1]    <= st_q[k];
        sx_q[k+1]    <= sx_q[k];
        sy_q[k+1]    <= sy_q[k];
        px_q[k+1]    <= px_q[k];
        py_q[k+1]    <= py_q[k];
      end
    end
  end

  // output register: apply direction sign, offset by P1, zero unless a hit
  logic signed [VW-1:0] offx, offy;
  logic signed [C-1:0]  hx_d, hy_d, hx_q, hy_q;
  status_e              sto_q;

  always_comb begin
    offx = sx_q[C] ? -VW'(qx_q[C]) : VW'(qx_q[C]);
    offy = sy_q[C] ? -VW'(qy_q[C]) : VW'(qy_q[C]);
    hx_d = '0;
    hy_d = '0;
    if (st_q[C] == ST_HIT) begin
      hx_d = px_q[C] + offx[C-1:0];
      hy_d = py_q[C] + offy[C-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sto_q <= st_q[C];
      hx_q  <= hx_d;
      hy_q  <= hy_d;
    end
  end

  assign m_axis_tvalid_o = vld_q[NST-1];
  assign m_axis_tdata_o  = OUT_W'({hy_q, hx_q, sto_q});

endmodule

// File: rtl/ssi_checker.sv
// ----------------------------------------------------------------------------
// ssi_checker: port-level checks for segment_segment_intersect
// Watches both streams and the result encoding; bound to the top level.
// ----------------------------------------------------------------------------
module ssi_checker
  import ssi_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic [((8*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata_i,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic [((2+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i
);

  localparam int unsigned C = COORD_BITS;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed under stall");

  // input side is never blocked while the output is empty
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != 2'd3)
    else $error("undefined status code");

  // no point reported without a hit
  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != ST_HIT |->
      m_axis_tdata_o[2*C+1:2] == '0)
    else $error("point given without a hit");

endmodule

bind segment_segment_intersect ssi_checker #(.COORD_BITS(COORD_BITS)) u_ssi_checker (.*);
